/* design/i2cps_pkg.sv */
// Shared types and constants for the two-wire bus master phase sequencer.
`timescale 1ns / 1ps

package i2cps_pkg;

  // Depth of the command queue between the front end and the phase engine.
  localparam int CMD_QUEUE_DEPTH = 2;

  // Longest command (write byte) produces this many phases.
  localparam int MAX_PHASES = 32;
  localparam int PHASE_W    = $clog2(MAX_PHASES);

  // Command codes.
  typedef enum logic [2:0] {
    FUNC_START    = 3'd0,
    FUNC_RESTART  = 3'd1,
    FUNC_STOP     = 3'd2,
    FUNC_WRITE    = 3'd3,
    FUNC_READ     = 3'd4,
    FUNC_ACK      = 3'd5,
    FUNC_NACK     = 3'd6,
    FUNC_WAIT_ACK = 3'd7
  } i2cps_func_t;

  // Input beat.
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] write_data;
    logic [7:0] line_in;
  } in_item_t;

  // Result beat, one per pin phase.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [2:0] hold_units;
    logic [7:0] read_data;
    logic       ack_missing;
    logic       bus_held;
    logic       status;
    logic       last;
  } out_item_t;

  // Classified command handed from the front end to the phase engine.
  typedef struct packed {
    i2cps_func_t func;
    logic [7:0]  write_data;
    logic [7:0]  line_in;
    logic        held_before;
    logic        status;
  } cmd_desc_t;

endpackage

/* design/i2cps_front.sv */
// Front end: accepts commands, tracks bus ownership and flags nested starts.
`timescale 1ns / 1ps

module i2cps_front
  import i2cps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      queue_full,
  output logic      push,
  output cmd_desc_t push_desc
);

  logic        held_r;
  logic        held_nxt;
  i2cps_func_t func;

  assign func     = i2cps_func_t'(in_data.func);
  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // Ownership follows command order only, so it can be resolved here
  // ahead of the phase engine.
  always_comb begin
    held_nxt = held_r;
    if (push) begin
      if (func == FUNC_START) begin
        held_nxt = 1'b1;
      end else if (func == FUNC_STOP) begin
        held_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    push_desc.func        = func;
    push_desc.write_data  = in_data.write_data;
    push_desc.line_in     = in_data.line_in;
    push_desc.held_before = held_r;
    push_desc.status      = (func == FUNC_START) && held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

endmodule

/* design/i2cps_queue.sv */
// Small command queue between the front end and the phase engine.
`timescale 1ns / 1ps

module i2cps_queue
  import i2cps_pkg::*;
#(
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_desc_t push_desc,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output cmd_desc_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_desc_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/i2cps_back.sv */
// Phase engine: expands the head command into pin phases, one per beat.
`timescale 1ns / 1ps

module i2cps_back
  import i2cps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_desc_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               advance;

  // Decoded phase.
  logic       drive_scl;
  logic       level;
  logic [2:0] hold;
  logic       lst;
  logic [7:0] rd;
  logic       nack;
  logic       held;

  assign advance = head_valid && (!out_valid_r || out_ready);
  assign pop     = advance && lst;

  always_comb begin
    drive_scl = 1'b0;
    level     = 1'b1;
    hold      = 3'd0;
    lst       = 1'b0;
    rd        = 8'd0;
    nack      = 1'b0;
    unique case (head.func)
      FUNC_START, FUNC_RESTART: begin
        case (phase_r)
          PHASE_W'(0): begin drive_scl = 1'b0; level = 1'b1; end
          PHASE_W'(1): begin drive_scl = 1'b1; level = 1'b1; end
          PHASE_W'(2): begin drive_scl = 1'b0; level = 1'b0; hold = 3'd2; end
          PHASE_W'(3): begin drive_scl = 1'b1; level = 1'b0; end
          default:     begin drive_scl = 1'b0; level = 1'b1; lst = 1'b1; end
        endcase
      end
      FUNC_STOP: begin
        case (phase_r)
          PHASE_W'(0): begin drive_scl = 1'b1; level = 1'b0; end
          PHASE_W'(1): begin drive_scl = 1'b0; level = 1'b0; hold = 3'd2; end
          PHASE_W'(2): begin drive_scl = 1'b1; level = 1'b1; end
          default:     begin drive_scl = 1'b0; level = 1'b1; lst = 1'b1; end
        endcase
      end
      FUNC_WRITE: begin
        // Four phases per bit, MSB first.
        unique case (phase_r[1:0])
          2'd0: begin
            drive_scl = 1'b0;
            level     = head.write_data[3'd7 - phase_r[4:2]];
          end
          2'd1: begin drive_scl = 1'b1; level = 1'b1; hold = 3'd4; end
          2'd2: begin drive_scl = 1'b1; level = 1'b0; end
          2'd3: begin
            drive_scl = 1'b0;
            level     = 1'b1;
            hold      = 3'd2;
            lst       = (phase_r == PHASE_W'(MAX_PHASES - 1));
          end
        endcase
      end
      FUNC_READ: begin
        // Release SDA, then a high and a low clock phase per bit.
        if (phase_r == '0) begin
          drive_scl = 1'b0;
          level     = 1'b1;
        end else if (phase_r[0]) begin
          drive_scl = 1'b1;
          level     = 1'b1;
          hold      = 3'd3;
        end else begin
          drive_scl = 1'b1;
          level     = 1'b0;
          hold      = 3'd5;
          lst       = (phase_r == PHASE_W'(16));
          rd        = lst ? head.line_in : 8'd0;
        end
      end
      FUNC_ACK, FUNC_NACK: begin
        case (phase_r)
          PHASE_W'(0): begin
            drive_scl = 1'b0;
            level     = (head.func == FUNC_NACK);
          end
          PHASE_W'(1): begin
            drive_scl = 1'b1;
            level     = 1'b1;
            hold      = (head.func == FUNC_NACK) ? 3'd5 : 3'd6;
          end
          default: begin drive_scl = 1'b1; level = 1'b0; lst = 1'b1; end
        endcase
      end
      FUNC_WAIT_ACK: begin
        if (phase_r == '0) begin
          drive_scl = 1'b1;
          level     = 1'b1;
          hold      = 3'd5;
        end else begin
          drive_scl = 1'b1;
          level     = 1'b0;
          lst       = 1'b1;
          nack      = head.line_in[0];
        end
      end
    endcase
  end

  always_comb begin
    if (head.func == FUNC_START) begin
      held = 1'b1;
    end else if (head.func == FUNC_STOP) begin
      held = lst ? 1'b0 : head.held_before;
    end else begin
      held = head.held_before;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      scl_nxt                  = drive_scl ? level : scl_r;
      sda_nxt                  = drive_scl ? sda_r : level;
      phase_nxt                = lst ? '0 : phase_r + 1'b1;
      out_valid_nxt            = 1'b1;
      out_data_nxt.scl_level   = scl_nxt;
      out_data_nxt.sda_level   = sda_nxt;
      out_data_nxt.hold_units  = hold;
      out_data_nxt.read_data   = rd;
      out_data_nxt.ack_missing = nack;
      out_data_nxt.bus_held    = held;
      out_data_nxt.status      = head.status;
      out_data_nxt.last        = lst;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/i2c_master_phase_sequencer_top.sv */
// Top level of the two-wire bus master phase sequencer.
`timescale 1ns / 1ps

// Each input beat carries one bus command (start, restart, stop, write byte,
// read byte, ack, no-ack, wait for ack) plus the byte to send and the sampled
// SDA levels. The block answers with one output beat per pin phase: the SCL
// and SDA levels after the phase, the hold count in delay units, and on the
// final phase the received byte or the acknowledge status.
// A command of N phases occupies the phase engine for N phase beats, one phase
// per cycle while the receiver keeps up: a write byte has 32 phases, a read
// byte 17, start and restart 5, stop 4, ack and no-ack 3, wait ack 2. The phase
// counter of the engine steps through them; the next command, if queued,
// follows its predecessor's last phase without a gap.
// The first phase of a command passes through the queue entry and then the
// output register when the engine is idle. Commands wait in a short queue, so
// the input keeps taking beats while the engine is busy until the queue fills.
// When the receiver stalls, the pending phase is held in the output register
// and the engine and queue stop behind it; nothing is dropped.
// Reset (rst_n low at a clock edge) empties the queue, marks the bus free
// and returns both pin levels to released high.
module i2c_master_phase_sequencer_top
  import i2cps_pkg::*;
#(
  parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Front end to queue.
  logic      push;
  cmd_desc_t push_desc;
  logic      queue_full;

  // Queue to phase engine.
  logic      head_valid;
  cmd_desc_t head;
  logic      pop;

  // The front end resolves bus ownership in command order, so the status
  // flag for a nested start is settled before the command is queued.
  i2cps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  i2cps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // The engine owns the pin levels, because every phase starts from the
  // levels left by the phase before it.
  i2cps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // A nested start always leaves the bus held.
  a_status_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.bus_held)
    else $error("status set on a phase with the bus free");

  // Received data and ack status only show on a final phase.
  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.read_data != 8'd0) || out_data.ack_missing)
      |-> out_data.last)
    else $error("result fields set on a phase that is not final");

  // Holds never exceed the longest defined phase.
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hold_units != 3'd7))
    else $error("hold count out of range");

  // A command is only retired from the queue on its final phase beat.
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid && out_data.last)
    else $error("command retired without a final phase");

endmodule
